// ===== hdl/cpd_pkg.sv =====
// cpd_pkg: shared constants, register codes and types for the channel presence detector
// no dependencies; used by cpd_cell and channel_presence_detector_top
package cpd_pkg;

  localparam int CHANNELS    = 8;
  localparam int SAMPLE_BITS = 12;

  localparam int IDX_BITS    = $clog2(CHANNELS);
  localparam int CNT_BITS    = $clog2(CHANNELS + 1);
  localparam int PEAK_BITS   = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;

  localparam int CHAN_BITS    = 3;
  localparam int STRENGTH_BITS = 12;
  localparam int TIME_BITS    = 32;
  localparam int MASK_BITS    = 8;
  localparam int NEAREST_BITS = 3;
  localparam int MARGIN_BITS  = 12;
  localparam int HOLD_BITS    = 16;
  localparam int PERIOD_BITS  = 16;
  localparam int FLOOR_BITS   = 12;

  localparam int ADDR_BITS    = 5;
  localparam int DATA_BITS    = 32;
  localparam int REG_IDX_BITS = 3;

  localparam logic [PEAK_BITS-1:0] SAMPLE_MASK = PEAK_BITS'((1 << SAMPLE_BITS) - 1);

  // register reset values
  localparam logic [MARGIN_BITS-1:0] NEAR_MARGIN_RST  = 12'd300;
  localparam logic [HOLD_BITS-1:0]   HOLD_MS_RST      = 16'd5000;
  localparam logic                   AUTO_RESET_RST   = 1'b1;
  localparam logic [TIME_BITS-1:0]   RESET_AGE_RST    = 32'd180000;
  localparam logic [PERIOD_BITS-1:0] CHECK_PERIOD_RST = 16'd10000;
  localparam logic [FLOOR_BITS-1:0]  PEAK_FLOOR_RST   = 12'd3000;

  // register indexes
  localparam logic [REG_IDX_BITS-1:0] REG_NEAR_MARGIN  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_HOLD_MS      = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_AUTO_RESET   = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_RESET_AGE    = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_CHECK_PERIOD = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_PEAK_FLOOR   = 3'd5;

  // settings each cell needs
  typedef struct packed {
    logic [MARGIN_BITS-1:0] near_margin;
    logic [HOLD_BITS-1:0]   hold_ms;
    logic [TIME_BITS-1:0]   reset_age_ms;
    logic [FLOOR_BITS-1:0]  peak_floor;
  } cfg_t;

  // the word being worked on, as seen by every cell
  typedef struct packed {
    logic                 chan_ok;
    logic [IDX_BITS-1:0]  chan;
    logic [PEAK_BITS-1:0] sample;
    logic [TIME_BITS-1:0] now_ms;
  } item_t;

  // phase strobes from the sequencer
  typedef struct packed {
    logic raise;
    logic sweep;
    logic near_upd;
  } cell_ctrl_t;

  // running best near time handed along the cell row
  typedef struct packed {
    logic [TIME_BITS-1:0] near_time;
    logic [IDX_BITS-1:0]  idx;
  } link_t;

endpackage

// ===== hdl/channel_presence_detector_top.sv =====
// channel_presence_detector_top: sequencer, settings registers and the row of channel cells
// depends on cpd_pkg and cpd_cell
//
//   port group   direction  handshake             contents
//   in           to block   in_valid / in_stall   channel_index, strength_sample, now_ms
//   out          from block out_valid / out_stall near_mask, nearest_channel, any_near
//   apb          to block   psel/penable/pready   settings registers at 4*index
//
// a word is taken only while the sequencer is idle, so a new word waits until the last
// result has been captured; the result is registered after the raise, near and scan phases
// the scan is the nearest-channel search, which walks the cell row one cell
// per cycle; the per-channel update itself runs as raise/sweep, then near
// rst is synchronous: peaks go to 3000, flags and near times to zero, settings to defaults
// a stalled result sits in the output register; the next word can already be taken then,
// and the row holds its finished search until the output register frees up
module channel_presence_detector_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // input words
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [cpd_pkg::CHAN_BITS-1:0]        channel_index,
  input  logic [cpd_pkg::STRENGTH_BITS-1:0]    strength_sample,
  input  logic [cpd_pkg::TIME_BITS-1:0]        now_ms,
  // result words
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [cpd_pkg::MASK_BITS-1:0]        near_mask,
  output logic [cpd_pkg::NEAREST_BITS-1:0]     nearest_channel,
  output logic                                 any_near,
  // settings port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cpd_pkg::ADDR_BITS-1:0]        paddr,
  input  logic [cpd_pkg::DATA_BITS-1:0]        pwdata,
  output logic [cpd_pkg::DATA_BITS-1:0]        prdata,
  output logic                                 pready
);

  // sequencer phases
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RAISE = 4'b0010,
    S_NEAR  = 4'b0100,
    S_SCAN  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // settings registers
  logic [cpd_pkg::MARGIN_BITS-1:0] near_margin;
  logic [cpd_pkg::HOLD_BITS-1:0]   hold_ms;
  logic                            auto_reset_enable;
  logic [cpd_pkg::TIME_BITS-1:0]   reset_age_ms;
  logic [cpd_pkg::PERIOD_BITS-1:0] check_period_ms;
  logic [cpd_pkg::FLOOR_BITS-1:0]  peak_floor;

  logic [cpd_pkg::REG_IDX_BITS-1:0] reg_idx;
  logic                             reg_wr;

  // word under work and sweep timer
  cpd_pkg::item_t                item;
  logic [cpd_pkg::TIME_BITS-1:0] next_sweep;
  logic [cpd_pkg::TIME_BITS:0]   sweep_sum;
  logic                          sweep_due;
  logic [cpd_pkg::CNT_BITS-1:0]  scan_cnt;

  logic in_take;
  logic out_take;
  logic capture;

  cpd_pkg::cfg_t       cfg;
  cpd_pkg::cell_ctrl_t ctrl;

  // cell row
  cpd_pkg::link_t                link [cpd_pkg::CHANNELS+1];
  logic [cpd_pkg::CHANNELS-1:0]  flags;
  logic [cpd_pkg::MASK_BITS-1:0] mask_now;

  // ---------------------------------------------------------------- settings port
  assign pready  = 1'b1;
  assign reg_idx = paddr[cpd_pkg::ADDR_BITS-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_margin       <= cpd_pkg::NEAR_MARGIN_RST;
      hold_ms           <= cpd_pkg::HOLD_MS_RST;
      auto_reset_enable <= cpd_pkg::AUTO_RESET_RST;
      reset_age_ms      <= cpd_pkg::RESET_AGE_RST;
      check_period_ms   <= cpd_pkg::CHECK_PERIOD_RST;
      peak_floor        <= cpd_pkg::PEAK_FLOOR_RST;
    end else if (reg_wr) begin
      case (reg_idx)
        cpd_pkg::REG_NEAR_MARGIN:  near_margin       <= pwdata[cpd_pkg::MARGIN_BITS-1:0];
        cpd_pkg::REG_HOLD_MS:      hold_ms           <= pwdata[cpd_pkg::HOLD_BITS-1:0];
        cpd_pkg::REG_AUTO_RESET:   auto_reset_enable <= pwdata[0];
        cpd_pkg::REG_RESET_AGE:    reset_age_ms      <= pwdata[cpd_pkg::TIME_BITS-1:0];
        cpd_pkg::REG_CHECK_PERIOD: check_period_ms   <= pwdata[cpd_pkg::PERIOD_BITS-1:0];
        cpd_pkg::REG_PEAK_FLOOR:   peak_floor        <= pwdata[cpd_pkg::FLOOR_BITS-1:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cpd_pkg::REG_NEAR_MARGIN:  prdata = cpd_pkg::DATA_BITS'(near_margin);
      cpd_pkg::REG_HOLD_MS:      prdata = cpd_pkg::DATA_BITS'(hold_ms);
      cpd_pkg::REG_AUTO_RESET:   prdata = cpd_pkg::DATA_BITS'(auto_reset_enable);
      cpd_pkg::REG_RESET_AGE:    prdata = cpd_pkg::DATA_BITS'(reset_age_ms);
      cpd_pkg::REG_CHECK_PERIOD: prdata = cpd_pkg::DATA_BITS'(check_period_ms);
      cpd_pkg::REG_PEAK_FLOOR:   prdata = cpd_pkg::DATA_BITS'(peak_floor);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input capture
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_take) begin
      // channel numbers past the row touch no cell
      item.chan_ok <= (32'(channel_index) < cpd_pkg::CHANNELS);
      item.chan    <= cpd_pkg::IDX_BITS'(channel_index);
      item.sample  <= cpd_pkg::PEAK_BITS'(strength_sample) & cpd_pkg::SAMPLE_MASK;
      item.now_ms  <= now_ms;
    end
  end

  // ---------------------------------------------------------------- sweep timer
  assign sweep_due = auto_reset_enable && (item.now_ms >= next_sweep);
  assign sweep_sum = {1'b0, item.now_ms} + (cpd_pkg::TIME_BITS + 1)'(check_period_ms);

  always_ff @(posedge clk) begin
    if (rst) begin
      next_sweep <= cpd_pkg::TIME_BITS'(cpd_pkg::CHECK_PERIOD_RST);
    end else if ((state == S_RAISE) && sweep_due) begin
      // saturate at the top of the time range
      next_sweep <= sweep_sum[cpd_pkg::TIME_BITS] ? '1 : sweep_sum[cpd_pkg::TIME_BITS-1:0];
    end
  end

  // ---------------------------------------------------------------- sequencer
  // scan_cnt reaching CHANNELS means the last cell holds the finished search
  assign capture = (state == S_SCAN) && (scan_cnt == cpd_pkg::CNT_BITS'(cpd_pkg::CHANNELS)) &&
                   (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  begin
        if (in_take) begin
          state_next = S_RAISE;
        end
      end
      S_RAISE: state_next = S_NEAR;
      S_NEAR:  state_next = S_SCAN;
      S_SCAN:  begin
        if (capture) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_cnt <= '0;
    end else begin
      state <= state_next;
      if (state != S_SCAN) begin
        scan_cnt <= '0;
      end else if (scan_cnt != cpd_pkg::CNT_BITS'(cpd_pkg::CHANNELS)) begin
        scan_cnt <= scan_cnt + cpd_pkg::CNT_BITS'(1);
      end
    end
  end

  assign ctrl.raise    = (state == S_RAISE);
  assign ctrl.sweep    = sweep_due;
  assign ctrl.near_upd = (state == S_NEAR);

  assign cfg.near_margin  = near_margin;
  assign cfg.hold_ms      = hold_ms;
  assign cfg.reset_age_ms = reset_age_ms;
  assign cfg.peak_floor   = peak_floor;

  // ---------------------------------------------------------------- cell row
  // the search enters at cell 0 with no winner and moves one cell per cycle
  assign link[0].near_time = '0;
  assign link[0].idx       = '0;

  for (genvar c = 0; c < cpd_pkg::CHANNELS; c++) begin : g_cell
    cpd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_id  (cpd_pkg::IDX_BITS'(c)),
      .ctrl     (ctrl),
      .cfg      (cfg),
      .item     (item),
      .link_in  (link[c]),
      .link_out (link[c+1]),
      .near     (flags[c])
    );
  end

  // only the first eight channels have a mask bit
  for (genvar m = 0; m < cpd_pkg::MASK_BITS; m++) begin : g_mask
    if (m < cpd_pkg::CHANNELS) begin : g_bit
      assign mask_now[m] = flags[m];
    end else begin : g_none
      assign mask_now[m] = 1'b0;
    end
  end

  // ---------------------------------------------------------------- output register
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (capture) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      near_mask       <= mask_now;
      nearest_channel <= cpd_pkg::NEAREST_BITS'(link[cpd_pkg::CHANNELS].idx);
      any_near        <= |flags;
    end
  end

  // ---------------------------------------------------------------- checks
  a_take_starts_update: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == S_RAISE))
    else $error("accepted word did not start the update phase");

  a_raise_then_near: assert property (@(posedge clk) disable iff (rst)
    (state == S_RAISE) |=> (state == S_NEAR))
    else $error("near update did not follow raise phase");

  a_result_from_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_SCAN))
    else $error("result word appeared outside the search phase");

  a_none_near_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !any_near) |-> (nearest_channel == '0))
    else $error("nearest channel nonzero with no channel near");

  a_timer_moves_in_raise: assert property (@(posedge clk) disable iff (rst)
    (state != S_RAISE) |=> $stable(next_sweep))
    else $error("sweep timer moved outside the raise phase");

endmodule

// ===== hdl/cpd_cell.sv =====
// cpd_cell: state of one receiver channel (peak, near flag, last near time)
// plus one stage of the nearest-channel search row; uses cpd_pkg types
module cpd_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [cpd_pkg::IDX_BITS-1:0]      cell_id,
  input  cpd_pkg::cell_ctrl_t               ctrl,
  input  cpd_pkg::cfg_t                     cfg,
  input  cpd_pkg::item_t                    item,
  input  cpd_pkg::link_t                    link_in,
  output cpd_pkg::link_t                    link_out,
  output logic                              near
);

  logic [cpd_pkg::PEAK_BITS-1:0] peak;
  logic [cpd_pkg::PEAK_BITS-1:0] peak_next;
  logic [cpd_pkg::TIME_BITS-1:0] last_near;
  logic [cpd_pkg::TIME_BITS-1:0] last_near_next;
  logic                          near_next;
  logic                          sel;
  logic                          stale;
  logic                          close;
  logic                          expired;
  logic                          better;

  assign sel = item.chan_ok && (item.chan == cell_id);

  // restore check: nonzero near time older than the reset age
  assign stale = (last_near != '0) &&
                 (({1'b0, last_near} + {1'b0, cfg.reset_age_ms}) < {1'b0, item.now_ms});

  assign close = ({1'b0, item.sample} + (cpd_pkg::PEAK_BITS + 1)'(cfg.near_margin)) >
                 {1'b0, peak};

  assign expired = ({1'b0, last_near} + (cpd_pkg::TIME_BITS + 1)'(cfg.hold_ms)) <
                   {1'b0, item.now_ms};

  always_comb begin
    peak_next      = peak;
    last_near_next = last_near;
    near_next      = near;
    if (ctrl.raise) begin
      if (sel && (item.sample > peak)) begin
        peak_next = item.sample;
      end
      if (ctrl.sweep && stale) begin
        peak_next      = cpd_pkg::PEAK_BITS'(cfg.peak_floor);
        last_near_next = '0;
      end
    end
    if (ctrl.near_upd && sel) begin
      if (close) begin
        near_next      = 1'b1;
        last_near_next = item.now_ms;
      end else if (expired) begin
        near_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak      <= cpd_pkg::PEAK_BITS'(cpd_pkg::PEAK_FLOOR_RST);
      last_near <= '0;
      near      <= 1'b0;
    end else begin
      peak      <= peak_next;
      last_near <= last_near_next;
      near      <= near_next;
    end
  end

  // strict compare keeps the lower index on ties; zero time never wins
  assign better = near && (last_near > link_in.near_time);

  always_ff @(posedge clk) begin
    if (better) begin
      link_out.near_time <= last_near;
      link_out.idx       <= cell_id;
    end else begin
      link_out <= link_in;
    end
  end

endmodule
